// ===== hdl/fixed_point_matvec_round_saturate_core_assert.svh =====
// Assertion macros for the matrix-vector core.
`ifndef FIXED_POINT_MATVEC_ROUND_SATURATE_CORE_ASSERT_SVH
`define FIXED_POINT_MATVEC_ROUND_SATURATE_CORE_ASSERT_SVH
`ifndef SYNTH
// Plain property on clk_i, held off during reset.
`define FPMV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpmv assertion failed");
// Same-cycle implication.
`define FPMV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpmv implication failed");
// Next-cycle implication.
`define FPMV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpmv next-cycle implication failed");
`else
`define FPMV_ASSERT(name, prop)
`define FPMV_ASSERT_IMP(name, ante, cons)
`define FPMV_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== hdl/fpmv_pkg.sv =====
// Shared types and constants of the matrix-vector core.
`timescale 1ns / 1ps
package fpmv_pkg;

  localparam int MAX_COLS_DEFAULT = 256;
  localparam int MAX_ROWS_DEFAULT = 4096;

  localparam int CFG_FRAC_W = 5;
  localparam int CFG_COLS_W = 9;
  localparam int CFG_ROWS_W = 13;
  localparam int ROW_IDX_W  = 12;
  localparam int APB_ADDR_W = 4;

  localparam logic [CFG_FRAC_W-1:0] FRAC_BITS_RESET    = 5'd16;
  localparam logic [CFG_COLS_W-1:0] COLUMN_COUNT_RESET = 9'd256;
  localparam logic [CFG_ROWS_W-1:0] ROW_COUNT_RESET    = 13'd1;

  localparam logic signed [31:0] RESULT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RESULT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_FRAC_BITS    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_ROW_COUNT    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD_VECTOR = 1'b0,
    OP_MATRIX_ELEM = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic [7:0]         elem_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]   row_result;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_row;
  } out_item_t;

  // Per-element tag carried down the pipe.
  typedef struct packed {
    logic                 first;
    logic                 eor;
    logic                 last;
    logic [ROW_IDX_W-1:0] row_idx;
  } elem_tag_t;

endpackage

// ===== hdl/fpmv_stream_if.sv =====
// Valid/ready stream interface carrying one payload item.
`timescale 1ns / 1ps
interface fpmv_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fixed_point_matvec_round_saturate_core.sv =====
// Fixed-point matrix-vector core: vector store, MAC pipeline, round/shift/saturate.
// Throughput: one input transaction per cycle while not stalled, loads and matrix items alike.
// Path: a row-ending matrix element reads the vector at the acceptance edge, then is
//   multiplied, accumulated, rounded and shifted/saturated into the output register,
//   each step a register of its own that a stall can hold.
// Stalls: a waiting result only blocks input once every pipeline slot holding a row end is full.
// Reset: rst_ni async active low clears valids, positions and accumulator and loads the config
//   registers with their reset values; vector store contents are undefined until loaded (no clearing pass).
`timescale 1ns / 1ps
`include "fixed_point_matvec_round_saturate_core_assert.svh"
module fixed_point_matvec_round_saturate_core
  import fpmv_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEFAULT,
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // streams
  fpmv_stream_if.sink           in_i,
  fpmv_stream_if.source         out_o
);

  // Widths derived from store and row limits.
  localparam int ColPosW = $clog2(MAX_COLS);
  localparam int ColCntW = $clog2(MAX_COLS + 1);
  localparam int CW      = (ColCntW > CFG_COLS_W) ? ColCntW : CFG_COLS_W;
  localparam int IdxW    = (ColCntW > 8) ? ColCntW : 8;
  localparam int RowPosW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RowCntW = $clog2(MAX_ROWS + 1);
  localparam int RW      = (RowCntW > CFG_ROWS_W) ? RowCntW : CFG_ROWS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_FRAC_W-1:0] frac_q;
  logic [CFG_COLS_W-1:0] cols_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_BITS_RESET;
      cols_q <= COLUMN_COUNT_RESET;
      rows_q <= ROW_COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAC_BITS:    frac_q <= pwdata[CFG_FRAC_W-1:0];
        REG_COLUMN_COUNT: cols_q <= pwdata[CFG_COLS_W-1:0];
        REG_ROW_COUNT:    rows_q <= pwdata[CFG_ROWS_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAC_BITS:    prdata = 32'(frac_q);
      REG_COLUMN_COUNT: prdata = 32'(cols_q);
      REG_ROW_COUNT:    prdata = 32'(rows_q);
      default:          prdata = '0;
    endcase
  end

  // Effective counts: zero means one, clipped at the store / row limits.
  logic [CW-1:0] eff_cols;
  logic [RW-1:0] eff_rows;

  always_comb begin
    if (cols_q == '0) begin
      eff_cols = CW'(1);
    end else if (CW'(cols_q) > CW'(MAX_COLS)) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = CW'(cols_q);
    end
    if (rows_q == '0) begin
      eff_rows = RW'(1);
    end else if (RW'(rows_q) > RW'(MAX_ROWS)) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(rows_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control.
  // Stage 1: matrix value + vector read data. Stage 2: product.
  // Stage 3: finished row sum. Stage 4: rounded sum. Then the output register.
  // Mid-row elements retire into the accumulator and never occupy stage 3.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic out_free, f4, f3, f2, f1;
  logic m1, m2, m3, m4;
  elem_tag_t tag1_q, tag2_q, tag3_q, tag4_q;

  assign out_free = !out_v_q || out_o.ready;
  assign f4       = !v4_q || out_free;
  assign f3       = !v3_q || f4;
  assign f2       = !v2_q || !tag2_q.eor || f3;
  assign f1       = !v1_q || f2;

  assign m4 = v4_q && out_free;
  assign m3 = v3_q && f4;
  assign m2 = v2_q && (!tag2_q.eor || f3);
  assign m1 = v1_q && f2;

  assign in_i.ready = f1;

  logic in_acc, ld_acc, mx_acc;
  assign in_acc = in_i.valid && in_i.ready;
  assign ld_acc = in_acc && (op_e'(in_i.data.operation) == OP_LOAD_VECTOR);
  assign mx_acc = in_acc && (op_e'(in_i.data.operation) == OP_MATRIX_ELEM);

  // ---------------------------------------------------------------------------
  // Matrix position tracking at the input.
  // ---------------------------------------------------------------------------
  logic [ColPosW-1:0] col_pos_q, col_pos_d;
  logic [RowPosW-1:0] row_pos_q, row_pos_d;
  logic [CW-1:0]      col_nxt;
  logic [RW-1:0]      row_nxt;
  elem_tag_t          tag0;

  assign col_nxt = CW'(col_pos_q) + CW'(1);
  assign row_nxt = RW'(row_pos_q) + RW'(1);

  always_comb begin
    tag0.first   = (col_pos_q == '0);
    tag0.eor     = (col_nxt >= eff_cols);
    tag0.last    = (row_nxt >= eff_rows);
    tag0.row_idx = ROW_IDX_W'(RW'(row_pos_q));

    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (ld_acc) begin
      // a load restarts the matrix
      col_pos_d = '0;
      row_pos_d = '0;
    end else if (mx_acc) begin
      if (tag0.eor) begin
        col_pos_d = '0;
        row_pos_d = tag0.last ? '0 : RowPosW'(row_nxt);
      end else begin
        col_pos_d = ColPosW'(col_nxt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Vector store: one access per cycle, write for a load, read for a matrix element.
  // ---------------------------------------------------------------------------
  logic [31:0]        vec_mem [MAX_COLS];
  logic [IdxW-1:0]    ld_idx;
  logic               ld_in_range;
  logic signed [31:0] vec1_q;
  logic signed [31:0] val1_q;

  assign ld_idx      = IdxW'(in_i.data.elem_index);
  assign ld_in_range = (ld_idx < IdxW'(MAX_COLS));

  always_ff @(posedge clk_i) begin
    if (ld_acc && ld_in_range) begin
      vec_mem[ld_idx[ColPosW-1:0]] <= in_i.data.elem_value;
    end
    if (mx_acc) begin
      vec1_q <= $signed(vec_mem[col_pos_q]);
      val1_q <= in_i.data.elem_value;
      tag1_q <= tag0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: full-width signed product.
  // ---------------------------------------------------------------------------
  logic signed [63:0] prod2_q;

  always_ff @(posedge clk_i) begin
    if (m1) begin
      prod2_q <= 64'(val1_q) * 64'(vec1_q);
      tag2_q  <= tag1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: accumulate; first column starts from zero, sum wraps mod 2^64.
  // ---------------------------------------------------------------------------
  logic [63:0] acc_q;
  logic [63:0] acc_sum;
  logic [63:0] rsum3_q;

  assign acc_sum = (tag2_q.first ? 64'd0 : acc_q) + prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (m2) begin
      acc_q <= acc_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m2 && tag2_q.eor) begin
      rsum3_q <= acc_sum;
      tag3_q  <= tag2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: add half an LSB away from zero.
  // ---------------------------------------------------------------------------
  logic [CFG_FRAC_W-1:0] frac_eff;
  logic [63:0]           half;
  logic [63:0]           rnd4_q;

  assign frac_eff = (frac_q == '0) ? CFG_FRAC_W'(1) : frac_q;
  assign half     = 64'd1 << (frac_eff - CFG_FRAC_W'(1));

  always_ff @(posedge clk_i) begin
    if (m3) begin
      rnd4_q <= rsum3_q[63] ? (rsum3_q - half) : (rsum3_q + half);
      tag4_q <= tag3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: arithmetic shift and saturate to int32.
  // ---------------------------------------------------------------------------
  logic signed [63:0] shifted;
  logic signed [31:0] sat_val;
  out_item_t          out_q;

  assign shifted = $signed(rnd4_q) >>> frac_eff;

  always_comb begin
    if ((&shifted[63:31]) || !(|shifted[63:31])) begin
      sat_val = shifted[31:0];
    end else begin
      sat_val = shifted[63] ? RESULT_MIN : RESULT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m4) begin
      out_q.row_result <= sat_val;
      out_q.row_index  <= tag4_q.row_idx;
      out_q.last_row   <= tag4_q.last;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q    <= mx_acc ? 1'b1 : (m1 ? 1'b0 : v1_q);
      v2_q    <= m1 ? 1'b1 : (m2 ? 1'b0 : v2_q);
      v3_q    <= (m2 && tag2_q.eor) ? 1'b1 : (m3 ? 1'b0 : v3_q);
      v4_q    <= m3 ? 1'b1 : (m4 ? 1'b0 : v4_q);
      out_v_q <= m4 ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // column position never leaves the store
  `FPMV_ASSERT(a_col_in_store, col_pos_q <= ColPosW'(MAX_COLS - 1))
  // input only blocked when the two front stages are both occupied
  `FPMV_ASSERT_IMP(a_block_full, !in_i.ready, v1_q && v2_q && tag2_q.eor)
  // a blocked row sum is held, not overwritten
  `FPMV_ASSERT_NXT(a_rsum_hold, v3_q && !f4, v3_q && $stable(rsum3_q))
  // a blocked rounded sum is held, not overwritten
  `FPMV_ASSERT_NXT(a_rnd_hold, v4_q && !out_free, v4_q && $stable(rnd4_q))

endmodule

// ===== dv/fpmv_row_checker.sv =====
// Row checker: mirrors register writes, predicts each row result and compares the output stream.
`timescale 1ns / 1ps
module fpmv_row_checker
  import fpmv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  fpmv_stream_if                in_mon_i,
  fpmv_stream_if                out_mon_i,
  output int                    mismatches_o,
  output int                    rows_pending_o
);

  localparam int VEC_DEPTH = MAX_COLS_DEFAULT;
  localparam int ROW_LIMIT = MAX_ROWS_DEFAULT;

  logic signed [31:0]    vec_mem [VEC_DEPTH];
  logic signed [63:0]    dot_acc;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [CFG_FRAC_W-1:0] frac_bits_q;
  logic [CFG_COLS_W-1:0] cols_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  int                    errors;
  out_item_t             row_results_due [$];

  // Half-unit rounding away from zero, arithmetic shift, clamp to int32.
  function automatic logic signed [31:0] round_shift_sat(input logic signed [63:0] sum,
                                                         input logic [CFG_FRAC_W-1:0] frac);
    int unsigned        shift;
    logic signed [63:0] half;
    logic signed [63:0] biased;
    logic signed [63:0] shifted;
    shift   = (frac == 0) ? 1 : frac;
    half    = 64'sd1 <<< (shift - 1);
    biased  = sum[63] ? sum - half : sum + half;
    shifted = biased >>> shift;
    if (shifted > RESULT_MAX) return RESULT_MAX;
    if (shifted < RESULT_MIN) return RESULT_MIN;
    return shifted[31:0];
  endfunction

  task automatic take_item(input in_item_t item);
    int unsigned        cols_eff;
    int unsigned        rows_eff;
    logic signed [63:0] a_ext;
    logic signed [63:0] b_ext;
    out_item_t          row;
    cols_eff = (cols_q == 0) ? 1 : ((cols_q > VEC_DEPTH) ? VEC_DEPTH : cols_q);
    rows_eff = (rows_q == 0) ? 1 : ((rows_q > ROW_LIMIT) ? ROW_LIMIT : rows_q);
    if (item.operation == OP_LOAD_VECTOR) begin
      vec_mem[item.elem_index] = item.elem_value;
      dot_acc = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      a_ext   = signed'(item.elem_value);
      b_ext   = vec_mem[col_pos];
      dot_acc = dot_acc + a_ext * b_ext;
      if (col_pos + 1 < cols_eff) begin
        col_pos++;
      end else begin
        row.row_result = round_shift_sat(dot_acc, frac_bits_q);
        row.row_index  = ROW_IDX_W'(row_pos);
        row.last_row   = (row_pos + 1 >= rows_eff);
        row_pos        = row.last_row ? 0 : row_pos + 1;
        dot_acc        = '0;
        col_pos        = 0;
        row_results_due.push_back(row);
      end
    end
  endtask

  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (row_results_due.size() == 0) begin
      $error("unexpected row result: row_result %0d row_index %0d last_row %0b",
             got.row_result, got.row_index, got.last_row);
      errors++;
    end else begin
      want = row_results_due.pop_front();
      if (got.row_result !== want.row_result) begin
        $error("row_result: expected %0d, got %0d", want.row_result, got.row_result);
        errors++;
      end
      if (got.row_index !== want.row_index) begin
        $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q = FRAC_BITS_RESET;
      cols_q      = COLUMN_COUNT_RESET;
      rows_q      = ROW_COUNT_RESET;
      dot_acc     = '0;
      col_pos     = 0;
      row_pos     = 0;
      errors      = 0;
      mismatches_o   <= 0;
      rows_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 2)
          REG_FRAC_BITS:    frac_bits_q = pwdata[CFG_FRAC_W-1:0];
          REG_COLUMN_COUNT: cols_q      = pwdata[CFG_COLS_W-1:0];
          REG_ROW_COUNT:    rows_q      = pwdata[CFG_ROWS_W-1:0];
          default: ;
        endcase
      end
      // output first: a result leaving now never belongs to an item entering now
      if (out_mon_i.valid && out_mon_i.ready) check_row(out_mon_i.data);
      if (in_mon_i.valid && in_mon_i.ready) take_item(in_mon_i.data);
      mismatches_o   <= errors;
      rows_pending_o <= row_results_due.size();
    end
  end

endmodule

// ===== dv/fixed_point_matvec_round_saturate_core_test.sv =====
// Testbench top: clock, reset, register writes, matrix/vector stimulus and the verdict.
`timescale 1ns / 1ps
module fixed_point_matvec_round_saturate_core_test
  import fpmv_pkg::*;
();

  localparam int ITEM_TARGET     = 1950;
  localparam int IDLE_PERCENT    = 24;
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the MAC pipe
  localparam int SETTLE_CYCLES   = 12;    // margin for rowless items still in flight to drain
  localparam int UNUSED_REG      = 3;     // index with no register behind it
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int STEADY_FIRST    = 900;   // items in [STEADY_FIRST, STEADY_LAST) see no idling
  localparam int STEADY_LAST     = 1200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  steady;
  logic                  squeeze_req;
  int                    mismatches;
  int                    rows_pending;
  int                    items_sent;
  // entries of the vector store loaded so far; a matrix item never reads any other
  bit                    vec_written [MAX_COLS_DEFAULT];

  fpmv_stream_if #(.item_t(in_item_t))  in_if ();
  fpmv_stream_if #(.item_t(out_item_t)) out_if ();

  fixed_point_matvec_round_saturate_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  fpmv_row_checker row_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Operand mix: extremes, small values, random magnitudes of either sign, full random.
  function automatic logic [31:0] pick_operand();
    logic [31:0] mag;
    case ($urandom_range(7))
      0: return RESULT_MIN;
      1: return RESULT_MAX;
      2: return 32'($urandom_range(16)) - 32'd8;
      3: begin
        mag = $urandom() >> $urandom_range(31);
        return $urandom_range(1) ? -mag : mag;
      end
      default: return $urandom();
    endcase
  endfunction

  // APB write: setup phase, access phase until pready, then an idle phase so psel drops cleanly.
  task automatic cfg_write(input int unsigned reg_no, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(reg_no * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // One input transaction, with random idle cycles in front of it outside the steady window.
  task automatic offer(input op_e op, input logic [7:0] idx, input logic [31:0] val);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{operation: op, elem_index: idx, elem_value: val};
    do @(posedge clk_i); while (!in_if.ready);
    if (op == OP_LOAD_VECTOR) vec_written[idx] = 1'b1;
    items_sent++;
    steady <= (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
  endtask

  // Drop valid right after the last accepted transaction, wait for every row, then let
  // rowless items still in flight drain before touching the registers.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      offer(OP_LOAD_VECTOR, 8'(i), pick_operand());
    end
  endtask

  // Receiver: random stalls, none during the steady window, and one long hold-off
  // when the stimulus asks for it.
  initial begin : result_sink
    bit held_off;
    held_off = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !held_off) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : stimulus
    int unsigned frac_v;
    int unsigned cols_v;
    int unsigned rows_v;
    int unsigned cols_eff;
    int unsigned budget;
    int unsigned noise_pct;
    int unsigned phase;
    int unsigned sel;
    bit          need_load;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    steady       <= 1'b0;
    squeeze_req  <= 1'b0;
    items_sent   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // All registers zero: each acts as one. A write to an unmapped index is dropped.
    cfg_write(REG_FRAC_BITS, 0);
    cfg_write(REG_COLUMN_COUNT, 0);
    cfg_write(REG_ROW_COUNT, 0);
    cfg_write(UNUSED_REG, 32'hFFFF_FFFF);
    offer(OP_LOAD_VECTOR, 8'd0, 32'd3);
    // one-column rows, positive and negative rounding at the half point
    offer(OP_MATRIX_ELEM, 8'hFF, 32'd5);
    offer(OP_MATRIX_ELEM, 8'h00, -32'sd5);
    settle();

    // Two columns, two rows: extreme products, saturation, last_row on the second row.
    cfg_write(REG_FRAC_BITS, 1);
    cfg_write(REG_COLUMN_COUNT, 2);
    cfg_write(REG_ROW_COUNT, 2);
    offer(OP_LOAD_VECTOR, 8'd0, RESULT_MIN);
    offer(OP_LOAD_VECTOR, 8'd1, RESULT_MAX);
    offer(OP_LOAD_VECTOR, 8'd2, RESULT_MIN);
    offer(OP_LOAD_VECTOR, 8'd3, RESULT_MIN);
    offer(OP_LOAD_VECTOR, 8'd255, 32'hFFFF_FFFF);
    offer(OP_MATRIX_ELEM, 8'd0, RESULT_MIN);
    offer(OP_MATRIX_ELEM, 8'd0, RESULT_MAX);
    offer(OP_MATRIX_ELEM, 8'd0, 32'hFFFF_FFFF);
    offer(OP_MATRIX_ELEM, 8'd0, 32'd1);
    // half a row left open across the register change below
    offer(OP_MATRIX_ELEM, 8'd0, 32'd7);
    settle();

    // Four columns now; the open row picks up at column one and ends at column three.
    cfg_write(REG_FRAC_BITS, 31);
    cfg_write(REG_COLUMN_COUNT, 4);
    cfg_write(REG_ROW_COUNT, 1);
    offer(OP_MATRIX_ELEM, 8'd0, 32'd1);
    offer(OP_MATRIX_ELEM, 8'd0, 32'd2);
    offer(OP_MATRIX_ELEM, 8'd0, 32'd3);
    // four products of 2^62: the 64-bit sum wraps to zero
    offer(OP_LOAD_VECTOR, 8'd0, RESULT_MIN);
    offer(OP_LOAD_VECTOR, 8'd1, RESULT_MIN);
    repeat (4) offer(OP_MATRIX_ELEM, 8'd0, RESULT_MIN);

    // ---- random part: one register setting per phase ----
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        // above-range counts clamp to the store and row limits
        0: begin frac_v = 31; cols_v = 511; rows_v = 8191; end
        1: begin frac_v = 1;  cols_v = 256; rows_v = 4096; end
        // one result per item while the receiver holds off: the pipe backs up
        2: begin frac_v = $urandom_range(31); cols_v = 1; rows_v = 5; end
        default: begin
          case ($urandom_range(4))
            0:       frac_v = 0;
            1:       frac_v = 31;
            2:       frac_v = 1;
            default: frac_v = $urandom_range(31);
          endcase
          sel = $urandom_range(14);
          if (sel == 0)     cols_v = $urandom_range(17, 511);
          else if (sel < 4) cols_v = $urandom_range(9, 16);
          else              cols_v = $urandom_range(0, 8);
          case ($urandom_range(5))
            0:       rows_v = 0;
            1:       rows_v = 1;
            2:       rows_v = $urandom_range(2, 6);
            3:       rows_v = $urandom_range(8191);
            4:       rows_v = 4096;
            default: rows_v = $urandom_range(7, 40);
          endcase
        end
      endcase

      settle();
      cfg_write(REG_FRAC_BITS, frac_v);
      cfg_write(REG_COLUMN_COUNT, cols_v);
      cfg_write(REG_ROW_COUNT, rows_v);
      cols_eff = (cols_v == 0) ? 1 : ((cols_v > MAX_COLS_DEFAULT) ? MAX_COLS_DEFAULT : cols_v);

      // Reload when the row would reach an entry never loaded, and now and then anyway.
      // Otherwise the matrix position carries over from the previous setting.
      need_load = ($urandom_range(3) == 0);
      for (int unsigned i = 0; i < cols_eff; i++) begin
        if (!vec_written[i]) need_load = 1'b1;
      end
      if (need_load) load_vector(cols_eff);

      if (phase == 2) squeeze_req <= 1'b1;

      // Wide rows get no stray loads, else a row would hardly ever complete.
      budget    = (cols_eff > 16) ? cols_eff + $urandom_range(1, 20) : $urandom_range(40, 120);
      noise_pct = (cols_eff > 16) ? 0 : 8;
      if (phase == 2) budget = 150;
      repeat (budget) begin
        if ($urandom_range(99) < noise_pct) begin
          offer(OP_LOAD_VECTOR, 8'($urandom_range(255)), pick_operand());
        end else begin
          offer(OP_MATRIX_ELEM, 8'($urandom_range(255)), pick_operand());
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== fixed_point_matvec_round_saturate_core.f =====
+incdir+hdl
hdl/fpmv_pkg.sv
hdl/fpmv_stream_if.sv
hdl/fixed_point_matvec_round_saturate_core.sv
dv/fpmv_row_checker.sv
dv/fixed_point_matvec_round_saturate_core_test.sv
